[hw/rtl/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

	// channel width, full scale (2^COLOR_BITS - 1) stands for 1.0
	localparam int COLOR_BITS = 8;
	localparam int HUE_BITS   = 15;

	// hue in 1/64 degree: one 60 degree sector and one full turn
	localparam int SECTOR_SPAN = 3840;
	localparam int FULL_TURN   = 23040;
	localparam int HALF_SPAN   = SECTOR_SPAN / 2;
	localparam int FRAC_BITS   = $clog2(SECTOR_SPAN + 1);

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// position of a hue on the color wheel
	typedef struct packed {
		sector_t                sector;
		logic [FRAC_BITS-1:0]   frac;
	} hue_pos_t;

endpackage

[hw/rtl/hsv2rgb_hsv_if.sv]
interface hsv2rgb_hsv_if;
	import hsv2rgb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [HUE_BITS-1:0]   hue;
	logic [COLOR_BITS-1:0] saturation;
	logic [COLOR_BITS-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);

endinterface

[hw/rtl/hsv2rgb_rgb_if.sv]
interface hsv2rgb_rgb_if;
	import hsv2rgb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);

endinterface

[hw/rtl/hsv_to_rgb_converter.sv]
// hsv to rgb pixel converter, five register stages
// throughput: one word per cycle while rgb.ready is high; each stage holds its word
// while the next is full, so bubbles are squeezed out and a stall loses nothing
// reset: arst_n clears the stage valid bits only, the data registers are not reset
module hsv_to_rgb_converter (
	input  logic          clk,
	input  logic          arst_n,
	hsv2rgb_hsv_if.sink   hsv,
	hsv2rgb_rgb_if.source rgb
);
	import hsv2rgb_pkg::*;

	localparam int CB      = COLOR_BITS;
	localparam int FULL    = (1 << CB) - 1;
	// product c * frac and the scaled-down numerator of the x quotient
	localparam int PW      = CB + FRAC_BITS;
	localparam int UW      = PW - 7;
	// 3840 = 256 * 15: a shift and then a division by 15 through a reciprocal
	localparam int RSH     = 4 * ((UW + 4 + 3) / 4);
	localparam int KW      = RSH - 3;
	localparam logic [KW-1:0] RECIP15 = KW'(((1 << RSH) - 1) / 15);

	// ---------------------------------------------------------------
	// handshake: a stage loads when it is empty or its word moves on
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5      = !v_s5 || rgb.ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign hsv.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= hsv.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: hue to sector and offset, brightness * saturation
	// ---------------------------------------------------------------
	hue_pos_t pos;

	hsv2rgb_hue_split u_hue_split (
		.hue (hsv.hue),
		.pos (pos)
	);

	sector_t              sector_s1;
	logic [FRAC_BITS-1:0] frac_s1;
	logic [2*CB-1:0]      vs_s1;
	logic [CB-1:0]        val_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sector_s1 <= pos.sector;
			frac_s1   <= pos.frac;
			vs_s1     <= (2*CB)'(hsv.brightness) * (2*CB)'(hsv.saturation);
			val_s1    <= hsv.brightness;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: c = round(v*s / full); falling edge of odd sectors
	// ---------------------------------------------------------------
	// round half up is floor((p + (full-1)/2) / full), and the division by
	// 2^n - 1 is exact as (t + (t >> n) + 1) >> n for t below 2^(2n) - 1
	logic [2*CB-1:0] c_num;
	logic [2*CB:0]   c_sum;
	logic [CB-1:0]   c_val;
	logic [FRAC_BITS-1:0] ramp;

	assign c_num = vs_s1 + (2*CB)'(FULL / 2);
	assign c_sum = {1'b0, c_num} + (2*CB+1)'(c_num >> CB) + (2*CB+1)'(1);
	assign c_val = c_sum[2*CB-1:CB];
	assign ramp  = sector_s1[0] ? (FRAC_BITS'(SECTOR_SPAN) - frac_s1) : frac_s1;

	sector_t              sector_s2;
	logic [FRAC_BITS-1:0] ramp_s2;
	logic [CB-1:0]        c_s2;
	logic [CB-1:0]        val_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sector_s2 <= sector_s1;
			ramp_s2   <= ramp;
			c_s2      <= c_val;
			val_s2    <= val_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: c * ramp and the offset m = v - c
	// ---------------------------------------------------------------
	sector_t       sector_s3;
	logic [PW-1:0] cr_s3;
	logic [CB-1:0] c_s3;
	logic [CB-1:0] m_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sector_s3 <= sector_s2;
			cr_s3     <= PW'(c_s2) * PW'(ramp_s2);
			c_s3      <= c_s2;
			m_s3      <= val_s2 - c_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: round(c*ramp / 3840) = floor(((p + 1920) >> 8) / 15),
	// quotient estimate by reciprocal, low by at most one
	// ---------------------------------------------------------------
	logic [PW:0]      x_num;
	logic [UW-1:0]    x_u;
	logic [UW+KW-1:0] x_prod;

	assign x_num  = {1'b0, cr_s3} + (PW+1)'(HALF_SPAN);
	assign x_u    = x_num[PW:8];
	assign x_prod = (UW+KW)'(x_u) * (UW+KW)'(RECIP15);

	sector_t       sector_s4;
	logic [UW-1:0] u_s4;
	logic [CB-1:0] q_s4;
	logic [CB-1:0] c_s4;
	logic [CB-1:0] m_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			sector_s4 <= sector_s3;
			u_s4      <= x_u;
			q_s4      <= x_prod[RSH+CB-1:RSH];
			c_s4      <= c_s3;
			m_s4      <= m_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: fix up the quotient, permute by sector, add m
	// ---------------------------------------------------------------
	logic [UW-1:0] q_ext;
	logic [UW-1:0] x_rem;
	logic [CB-1:0] x_val;
	logic [CB-1:0] r_ch, g_ch, b_ch;

	assign q_ext = UW'(q_s4);
	assign x_rem = u_s4 - ((q_ext << 4) - q_ext);
	assign x_val = (x_rem >= UW'(15)) ? (q_s4 + CB'(1)) : q_s4;

	always_comb begin
		unique case (sector_s4)
			SEC_RED_YEL: begin r_ch = c_s4;  g_ch = x_val; b_ch = '0;    end
			SEC_YEL_GRN: begin r_ch = x_val; g_ch = c_s4;  b_ch = '0;    end
			SEC_GRN_CYN: begin r_ch = '0;    g_ch = c_s4;  b_ch = x_val; end
			SEC_CYN_BLU: begin r_ch = '0;    g_ch = x_val; b_ch = c_s4;  end
			SEC_BLU_MAG: begin r_ch = x_val; g_ch = '0;    b_ch = c_s4;  end
			default:     begin r_ch = c_s4;  g_ch = '0;    b_ch = x_val; end
		endcase
	end

	logic [CB-1:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			red_s5   <= r_ch + m_s4;
			green_s5 <= g_ch + m_s4;
			blue_s5  <= b_ch + m_s4;
		end
	end

	assign rgb.valid = v_s5;
	assign rgb.red   = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue  = blue_s5;

endmodule

[hw/rtl/hsv2rgb_hue_split.sv]
module hsv2rgb_hue_split (
	input  logic [hsv2rgb_pkg::HUE_BITS-1:0] hue,
	output hsv2rgb_pkg::hue_pos_t            pos
);
	import hsv2rgb_pkg::*;

	logic [HUE_BITS-1:0] wrapped;
	logic [HUE_BITS-1:0] base;

	// fold a full turn and anything above it back onto the wheel
	always_comb begin
		if (hue >= HUE_BITS'(FULL_TURN)) begin
			wrapped = hue - HUE_BITS'(FULL_TURN);
		end else begin
			wrapped = hue;
		end
	end

	always_comb begin
		if (wrapped >= HUE_BITS'(5 * SECTOR_SPAN)) begin
			pos.sector = SEC_MAG_RED;
			base       = HUE_BITS'(5 * SECTOR_SPAN);
		end else if (wrapped >= HUE_BITS'(4 * SECTOR_SPAN)) begin
			pos.sector = SEC_BLU_MAG;
			base       = HUE_BITS'(4 * SECTOR_SPAN);
		end else if (wrapped >= HUE_BITS'(3 * SECTOR_SPAN)) begin
			pos.sector = SEC_CYN_BLU;
			base       = HUE_BITS'(3 * SECTOR_SPAN);
		end else if (wrapped >= HUE_BITS'(2 * SECTOR_SPAN)) begin
			pos.sector = SEC_GRN_CYN;
			base       = HUE_BITS'(2 * SECTOR_SPAN);
		end else if (wrapped >= HUE_BITS'(SECTOR_SPAN)) begin
			pos.sector = SEC_YEL_GRN;
			base       = HUE_BITS'(SECTOR_SPAN);
		end else begin
			pos.sector = SEC_RED_YEL;
			base       = '0;
		end
	end

	logic [HUE_BITS-1:0] offset;
	assign offset   = wrapped - base;
	assign pos.frac = offset[FRAC_BITS-1:0];

endmodule
